// ===== design/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and codes of the smooth damp follower: transaction payloads,
// register indexes, datapath step codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

	// field widths of the transactions and registers
	localparam int VAL_W     = 32;
	localparam int DT_W      = 17;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_TIME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 1'b1;

	// datapath steps, run in this order
	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_OMEGA  = 4'd0;
	localparam step_t ST_X      = 4'd1;
	localparam step_t ST_X2     = 4'd2;
	localparam step_t ST_X3     = 4'd3;
	localparam step_t ST_DEN2   = 4'd4;
	localparam step_t ST_DEN3   = 4'd5;
	localparam step_t ST_DECAY  = 4'd6;
	localparam step_t ST_MAXC   = 4'd7;
	localparam step_t ST_LIMIT  = 4'd8;
	localparam step_t ST_TEMPA  = 4'd9;
	localparam step_t ST_TEMPB  = 4'd10;
	localparam step_t ST_NVELA  = 4'd11;
	localparam step_t ST_NVELB  = 4'd12;
	localparam step_t ST_RESULT = 4'd13;
	localparam step_t ST_GUARD  = 4'd14;
	localparam step_t ST_SNAPV  = 4'd15;

	// input transaction
	typedef struct packed {
		logic signed [VAL_W-1:0] target;
		logic [DT_W-1:0]         delta_time;
	} in_item_t;

	// output transaction
	typedef struct packed {
		logic signed [VAL_W-1:0] position;
		logic signed [VAL_W-1:0] velocity;
		logic                    snapped;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic  load;
		logic  start;
		step_t step;
		logic  out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;
		logic snap;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== design/sdf_mul.sv =====
// ----------------------------------------------------------------------------
// sdf_mul
// Sequential fixed point multiplier: magnitude times magnitude, one 16-bit
// digit of the second operand per cycle, then rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_mul #(
	parameter int DW = 32,
	parameter int FW = 16,
	parameter int AW = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [AW:0]   a,
	input  wire logic signed [DW-1:0] b,
	output logic                      done,
	output logic signed [DW-1:0]      res
);

	localparam int CW   = 16;
	localparam int NCH  = (DW + CW - 1) / CW;
	localparam int BW   = NCH * CW;
	localparam int PW   = AW + BW;
	localparam int RW   = PW + 1 - FW;
	localparam int CNTW = $clog2(NCH + 1);

	localparam logic [PW:0]   HALF  = (PW + 1)'(1) << (FW - 1);
	localparam logic [RW-1:0] LIM_P = RW'({(DW - 1){1'b1}});
	localparam logic [RW-1:0] LIM_N = LIM_P + RW'(1);
	localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW - 1){1'b1}}};
	localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW - 1){1'b0}}};

	logic                 busy_q;
	logic                 done_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 neg_q;
	logic [AW-1:0]        am_q;
	logic [BW-1:0]        bm_q;
	logic [PW-1:0]        acc_q;
	logic signed [DW-1:0] res_q;

	logic signed [AW:0]   a_abs;
	logic signed [DW:0]   b_ext;
	logic signed [DW:0]   b_abs;
	logic [AW+CW-1:0]     pp;
	logic [PW:0]          rnd;
	logic [RW-1:0]        mag_r;
	logic signed [DW-1:0] res_d;

	// operand magnitudes, partial product, rounding and saturation
	always_comb begin
		a_abs = a[AW] ? -a : a;
		b_ext = (DW + 1)'(b);
		b_abs = b[DW-1] ? -b_ext : b_ext;
		pp    = am_q * bm_q[BW-1 -: CW];
		rnd   = {1'b0, acc_q} + HALF;
		mag_r = rnd[PW:FW];
		if (mag_r > (neg_q ? LIM_N : LIM_P)) begin
			res_d = neg_q ? VMIN : VMAX;
		end else if (neg_q) begin
			res_d = -signed'(mag_r[DW-1:0]);
		end else begin
			res_d = signed'(mag_r[DW-1:0]);
		end
	end

	// digit counter and handshake with the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NCH);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CNTW'(1);
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-and-accumulate, most significant digit first
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[AW] ^ b[DW-1];
			am_q  <= a_abs[AW-1:0];
			bm_q  <= BW'(b_abs[DW-1:0]);
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				acc_q <= (acc_q << CW) + PW'(pp);
				bm_q  <= bm_q << CW;
			end else begin
				res_q <= res_d;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

// ===== design/sdf_div.sv =====
// ----------------------------------------------------------------------------
// sdf_div
// Sequential fixed point divider: restoring division of num*2^FW by den,
// one quotient bit per cycle, rounded to nearest and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_div #(
	parameter int DW = 32,
	parameter int FW = 16,
	parameter int AW = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [AW:0]   num,
	input  wire logic signed [DW-1:0] den,
	output logic                      done,
	output logic signed [DW-1:0]      res
);

	localparam int NW   = AW + FW;
	localparam int CNTW = $clog2(NW + 1);

	localparam logic [NW:0] LIM_P = (NW + 1)'({(DW - 1){1'b1}});
	localparam logic [NW:0] LIM_N = LIM_P + (NW + 1)'(1);
	localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW - 1){1'b1}}};
	localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW - 1){1'b0}}};

	logic                 busy_q;
	logic                 done_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 neg_q;
	logic                 nsign_q;
	logic                 nz_q;
	logic                 dz_q;
	logic [NW-1:0]        n_q;
	logic [NW-1:0]        q_q;
	logic [DW:0]          r_q;
	logic [DW-1:0]        ub_q;
	logic signed [DW-1:0] res_q;

	logic signed [AW:0]   num_abs;
	logic signed [DW:0]   den_ext;
	logic signed [DW:0]   den_abs;
	logic [DW:0]          r2;
	logic                 ge;
	logic                 up;
	logic [NW:0]          qr;
	logic signed [DW-1:0] res_d;

	// one restoring step, final rounding and saturation
	always_comb begin
		num_abs = num[AW] ? -num : num;
		den_ext = (DW + 1)'(den);
		den_abs = den[DW-1] ? -den_ext : den_ext;
		r2      = {r_q[DW-1:0], n_q[NW-1]};
		ge      = r2 >= {1'b0, ub_q};
		up      = r_q >= ({1'b0, ub_q} - r_q);
		qr      = {1'b0, q_q} + (NW + 1)'(up);
		if (nz_q) begin
			res_d = '0;
		end else if (dz_q) begin
			res_d = nsign_q ? VMIN : VMAX;
		end else if (qr > (neg_q ? LIM_N : LIM_P)) begin
			res_d = neg_q ? VMIN : VMAX;
		end else if (neg_q) begin
			res_d = -signed'(qr[DW-1:0]);
		end else begin
			res_d = signed'(qr[DW-1:0]);
		end
	end

	// bit counter and handshake with the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CNTW'(1);
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q   <= num[AW] ^ den[DW-1];
			nsign_q <= num[AW];
			nz_q    <= num == '0;
			dz_q    <= den == '0;
			n_q     <= {num_abs[AW-1:0], {FW{1'b0}}};
			ub_q    <= den_abs[DW-1:0];
			r_q     <= '0;
			q_q     <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				r_q <= ge ? r2 - {1'b0, ub_q} : r2;
				q_q <= {q_q[NW-2:0], ge};
				n_q <= n_q << 1;
			end else begin
				res_q <= res_d;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

// ===== design/sdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdf_ctrl
// Controller of the smooth damp follower: takes a transaction, walks the
// datapath through its steps and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output sdf_pkg::dp_cmd_t      cmd,
	input  wire sdf_pkg::dp_stat_t stat
);

	import sdf_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ISSUE  = 2'd1;
	localparam logic [1:0] S_WAIT   = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	step_t      step_q;
	logic       result_valid_q;
	logic       out_load;

	assign out_load = (state_q == S_FINISH) && (!result_valid_q || result_ready);

	// commands to the datapath
	always_comb begin
		item_ready   = state_q == S_IDLE;
		cmd.load     = item_valid && (state_q == S_IDLE);
		cmd.start    = state_q == S_ISSUE;
		cmd.step     = step_q;
		cmd.out_load = out_load;
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_OMEGA;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_ISSUE;
						step_q  <= ST_OMEGA;
					end
				end
				S_ISSUE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (stat.done) begin
						if (step_q == ST_GUARD) begin
							if (stat.snap) begin
								step_q  <= ST_SNAPV;
								state_q <= S_ISSUE;
							end else begin
								state_q <= S_FINISH;
							end
						end else if (step_q == ST_SNAPV) begin
							state_q <= S_FINISH;
						end else begin
							step_q  <= step_q + STEP_W'(1);
							state_q <= S_ISSUE;
						end
					end
				end
				S_FINISH: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

// ===== design/sdf_dp.sv =====
// ----------------------------------------------------------------------------
// sdf_dp
// Datapath of the smooth damp follower: configuration, held position and
// velocity, working registers, the shared multiplier and divider, and the
// limit and overshoot steps.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_dp #(
	parameter int DW = 32,
	parameter int FW = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire sdf_pkg::dp_cmd_t                    cmd,
	output sdf_pkg::dp_stat_t                        stat,
	input  wire sdf_pkg::in_item_t                   item,
	input  wire logic                                cfg_we,
	input  wire logic [sdf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sdf_pkg::CFG_W-1:0]           cfg_wdata,
	output sdf_pkg::out_item_t                       result
);

	import sdf_pkg::*;

	// operand width of the units: holds data values and the constants
	localparam int MW = (DW > FW + 2) ? DW : FW + 2;
	// width for exact sums before saturation
	localparam int EW = ((MW > VAL_W) ? MW : VAL_W) + 2;

	localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW - 1){1'b1}}};
	localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW - 1){1'b0}}};
	localparam logic signed [EW-1:0] VMAX_E = {{(EW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
	localparam logic signed [EW-1:0] VMIN_E = {{(EW - DW + 1){1'b1}}, {(DW - 1){1'b0}}};
	localparam logic signed [EW-1:0] ONE_E = {{(EW - FW - 1){1'b0}}, 1'b1, {FW{1'b0}}};
	localparam logic signed [MW:0]   ONE_A = {{(MW - FW){1'b0}}, 1'b1, {FW{1'b0}}};
	localparam logic signed [MW:0]   TWO_A = {{(MW - FW - 1){1'b0}}, 1'b1, {(FW + 1){1'b0}}};
	localparam longint K048_V  = ((longint'(48) << FW) + 50) / 100;
	localparam longint K0235_V = ((longint'(235) << FW) + 500) / 1000;
	localparam logic signed [MW:0] K048_A  = (MW + 1)'(K048_V);
	localparam logic signed [MW:0] K0235_A = (MW + 1)'(K0235_V);

	function automatic logic signed [EW-1:0] ext(input logic signed [DW-1:0] v);
		return EW'(v);
	endfunction

	function automatic logic signed [MW:0] to_a(input logic signed [DW-1:0] v);
		return (MW + 1)'(v);
	endfunction

	function automatic logic signed [DW-1:0] sat_e(input logic signed [EW-1:0] v);
		if (v > VMAX_E) begin
			return VMAX;
		end else if (v < VMIN_E) begin
			return VMIN;
		end
		return v[DW-1:0];
	endfunction

	// configuration registers
	logic [CFG_W-1:0] st_cfg_q;
	logic [CFG_W-1:0] ms_cfg_q;

	// held state and per-item registers
	logic signed [DW-1:0] cur_q;
	logic signed [DW-1:0] vel_q;
	logic                 snap_q;
	logic                 alu_done_q;
	logic signed [DW-1:0] orig_q;
	logic signed [DW-1:0] dt_q;
	logic signed [DW-1:0] omega_q;
	logic signed [DW-1:0] x_q;
	logic signed [DW-1:0] x2_q;
	logic signed [DW-1:0] x3_q;
	logic signed [DW-1:0] den_q;
	logic signed [DW-1:0] decay_q;
	logic signed [DW-1:0] maxc_q;
	logic signed [DW-1:0] chg_q;
	logic signed [DW-1:0] tt_q;
	logic signed [DW-1:0] s_q;
	logic signed [DW-1:0] temp_q;
	logic signed [DW-1:0] nvel_q;
	logic signed [DW-1:0] result_q;
	out_item_t            out_q;

	logic signed [DW-1:0] st_d;
	logic signed [DW-1:0] ms_d;
	logic                 use_div;
	logic                 use_alu;
	logic                 mul_start;
	logic                 div_start;
	logic signed [MW:0]   mul_a;
	logic signed [DW-1:0] mul_b;
	logic signed [MW:0]   div_num;
	logic signed [DW-1:0] div_den;
	logic                 mul_done;
	logic                 div_done;
	logic signed [DW-1:0] mul_res;
	logic signed [DW-1:0] div_res;
	logic signed [DW-1:0] chg0;
	logic signed [EW-1:0] chg0_e;
	logic signed [EW-1:0] chg_abs;
	logic signed [DW-1:0] lim_chg;
	logic signed [DW-1:0] lim_tt;
	logic                 snap_w;

	// register values clamped to the data range
	assign st_d = sat_e(EW'(st_cfg_q));
	assign ms_d = sat_e(EW'(ms_cfg_q));

	// unit selection per step
	always_comb begin
		use_div = 1'b0;
		use_alu = 1'b0;
		case (cmd.step) inside
			ST_OMEGA, ST_DECAY, ST_SNAPV: use_div = 1'b1;
			ST_LIMIT, ST_GUARD:           use_alu = 1'b1;
			default: ;
		endcase
	end

	assign mul_start = cmd.start && !use_div && !use_alu;
	assign div_start = cmd.start && use_div;

	// multiplier operands
	always_comb begin
		case (cmd.step)
			ST_X: begin
				mul_a = to_a(omega_q);
				mul_b = dt_q;
			end
			ST_X2: begin
				mul_a = to_a(x_q);
				mul_b = x_q;
			end
			ST_X3: begin
				mul_a = to_a(x2_q);
				mul_b = x_q;
			end
			ST_DEN2: begin
				mul_a = K048_A;
				mul_b = x2_q;
			end
			ST_DEN3: begin
				mul_a = K0235_A;
				mul_b = x3_q;
			end
			ST_MAXC: begin
				mul_a = to_a(ms_d);
				mul_b = dt_q;
			end
			ST_TEMPA: begin
				mul_a = to_a(omega_q);
				mul_b = chg_q;
			end
			ST_TEMPB: begin
				mul_a = to_a(s_q);
				mul_b = dt_q;
			end
			ST_NVELA: begin
				mul_a = to_a(omega_q);
				mul_b = temp_q;
			end
			ST_NVELB: begin
				mul_a = to_a(s_q);
				mul_b = decay_q;
			end
			ST_RESULT: begin
				mul_a = to_a(sat_e(ext(chg_q) + ext(temp_q)));
				mul_b = decay_q;
			end
			default: begin
				mul_a = to_a(omega_q);
				mul_b = dt_q;
			end
		endcase
	end

	// divider operands
	always_comb begin
		case (cmd.step)
			ST_OMEGA: begin
				div_num = TWO_A;
				div_den = st_d;
			end
			ST_DECAY: begin
				div_num = ONE_A;
				div_den = den_q;
			end
			default: begin
				div_num = to_a(sat_e(ext(result_q) - ext(orig_q)));
				div_den = dt_q;
			end
		endcase
	end

	// speed limit and overshoot test
	always_comb begin
		chg0    = sat_e(ext(cur_q) - ext(orig_q));
		chg0_e  = ext(chg0);
		chg_abs = chg0_e[EW-1] ? -chg0_e : chg0_e;
		if (chg_abs > ext(maxc_q)) begin
			lim_chg = (chg0 > 0) ? maxc_q : sat_e(-ext(maxc_q));
			lim_tt  = sat_e(ext(cur_q) - ext(lim_chg));
		end else begin
			lim_chg = chg0;
			lim_tt  = orig_q;
		end
		snap_w = (cur_q > orig_q) != (result_q > orig_q);
	end

	sdf_mul #(
		.DW (DW),
		.FW (FW),
		.AW (MW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	sdf_div #(
		.DW (DW),
		.FW (FW),
		.AW (MW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.res    (div_res)
	);

	// configuration, held state and completion of the limit and guard steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_cfg_q   <= CFG_W'(65536);
			ms_cfg_q   <= {CFG_W{1'b1}};
			cur_q      <= '0;
			vel_q      <= '0;
			snap_q     <= 1'b0;
			alu_done_q <= 1'b0;
		end else begin
			alu_done_q <= cmd.start && use_alu;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SMOOTH_TIME: st_cfg_q <= cfg_wdata;
					REG_MAX_SPEED:   ms_cfg_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.start && (cmd.step == ST_GUARD)) begin
				snap_q <= snap_w;
				if (snap_w) begin
					cur_q <= orig_q;
				end else begin
					cur_q <= result_q;
					vel_q <= nvel_q;
				end
			end
			if (div_done && (cmd.step == ST_SNAPV)) begin
				vel_q <= div_res;
			end
		end
	end

	// working registers, loaded with each item and written by the steps
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			orig_q <= sat_e(EW'(signed'(item.target)));
			dt_q   <= sat_e(EW'(item.delta_time));
		end
		if (cmd.start && (cmd.step == ST_LIMIT)) begin
			chg_q <= lim_chg;
			tt_q  <= lim_tt;
		end
		if (div_done) begin
			case (cmd.step)
				ST_OMEGA: omega_q <= div_res;
				ST_DECAY: decay_q <= div_res;
				default: ;
			endcase
		end
		if (mul_done) begin
			case (cmd.step)
				ST_X:      x_q      <= mul_res;
				ST_X2:     x2_q     <= mul_res;
				ST_X3:     x3_q     <= mul_res;
				ST_DEN2:   den_q    <= sat_e(ext(sat_e(ONE_E + ext(x_q))) + ext(mul_res));
				ST_DEN3:   den_q    <= sat_e(ext(den_q) + ext(mul_res));
				ST_MAXC:   maxc_q   <= mul_res;
				ST_TEMPA:  s_q      <= sat_e(ext(vel_q) + ext(mul_res));
				ST_TEMPB:  temp_q   <= mul_res;
				ST_NVELA:  s_q      <= sat_e(ext(vel_q) - ext(mul_res));
				ST_NVELB:  nvel_q   <= mul_res;
				ST_RESULT: result_q <= sat_e(ext(tt_q) + ext(mul_res));
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			out_q.position <= VAL_W'(cur_q);
			out_q.velocity <= VAL_W'(vel_q);
			out_q.snapped  <= snap_q;
		end
	end

	assign stat.done = mul_done || div_done || alu_done_q;
	assign stat.snap = snap_q;
	assign result    = out_q;

endmodule

`default_nettype wire

// ===== design/smooth_damp_follower.sv =====
// ----------------------------------------------------------------------------
// smooth_damp_follower
// Critically damped follower: moves a held position and velocity toward each
// incoming target, in signed fixed point with saturating arithmetic.
//
// Usage:
//   item channel   (item_valid/item_ready/item): target and time step.
//   result channel (result_valid/result_ready/result): new position,
//   velocity and the overshoot flag, one result per item.
//   cfg port (cfg_we/cfg_index/cfg_wdata): smooth_time and max_speed; the user
//   writes them only while the block is idle, which the block does not enforce.
// Each item runs 11 multiplies and 2 divides through one shared multiplier
//   and one shared divider; a third divide computes the velocity when the
//   overshoot guard fires.
// Throughput: one item at a time; the next item is taken the cycle after
//   the previous result enters the output register.
// Reset: position and velocity clear to zero, smooth_time to 1.0 and
//   max_speed to its largest value.
// Stall: the output register holds a result while result_ready is low; the
//   block takes and works the next item meanwhile and waits before writing
//   its result.
// ----------------------------------------------------------------------------
`default_nettype none

module smooth_damp_follower #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire sdf_pkg::in_item_t             item,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output sdf_pkg::out_item_t                 result,
	input  wire logic                          cfg_we,
	input  wire logic [sdf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sdf_pkg::CFG_W-1:0]     cfg_wdata
);

	import sdf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// step sequencer and output handshake
	sdf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.stat         (stat)
	);

	// arithmetic, state and output register
	sdf_dp #(
		.DW (DATA_WIDTH),
		.FW (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the smooth damp follower. Targets and time steps go
// in over the item channel under several smooth_time / max_speed settings. A
// fixed-point model of the follower predicts each result, and the monitor
// compares every returned result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	import sdf_pkg::*;

	localparam int     FRAC  = 16;
	localparam longint VMAX  = (longint'(1) << (VAL_W - 1)) - 1;
	localparam longint VMIN  = -VMAX - 1;
	localparam longint ONE_Q = longint'(1) << FRAC;
	localparam longint K048  = ((longint'(48) << FRAC) + 50) / 100;
	localparam longint K0235 = ((longint'(235) << FRAC) + 500) / 1000;
	localparam int     RANDOM_PER_PHASE = 70;
	localparam int     PHASES = 8;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_ready;
	in_item_t         item = '0;
	logic             result_valid;
	logic             result_ready = 1'b1;
	out_item_t        result;
	logic             cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SMOOTH_TIME;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// follower model state and register copies
	longint held_pos = 0;
	longint held_vel = 0;
	longint cfg_smooth = 65536;
	longint cfg_speed = 32'h7FFF_FFFF;

	in_item_t  target_queue[$];
	out_item_t predicted_moves[$];
	int        mismatch_count = 0;
	int        cycle_no = 0;
	bit        item_taken = 1'b0;
	int        send_gap = 0;
	int        recv_gap = 0;
	logic signed [VAL_W-1:0] goal = '0;

	smooth_damp_follower dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #5 clk = ~clk;

	// saturating fixed-point helpers
	function automatic longint q_sat(longint v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	function automatic logic [127:0] q_mag(longint v);
		return v < 0 ? 128'(-v) : 128'(v);
	endfunction

	function automatic longint q_from_mag(bit neg, logic [127:0] m);
		if (neg) begin
			if (m > 128'(VMAX) + 128'd1) return VMIN;
			return -longint'(m[63:0]);
		end
		if (m > 128'(VMAX)) return VMAX;
		return longint'(m[63:0]);
	endfunction

	// product rounded to nearest, ties away from zero
	function automatic longint q_mul(longint a, longint b);
		logic [127:0] prod;
		prod = q_mag(a) * q_mag(b);
		prod = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
		return q_from_mag((a < 0) != (b < 0), prod);
	endfunction

	// quotient a/b in fixed point, same rounding; zero divisor saturates
	function automatic longint q_div(longint a, longint b);
		logic [127:0] ua, ub, quo, rem;
		ua = q_mag(a);
		ub = q_mag(b);
		if (ua == 0) return 0;
		if (ub == 0) return a < 0 ? VMIN : VMAX;
		quo = (ua << FRAC) / ub;
		rem = (ua << FRAC) % ub;
		if (rem >= ub - rem) quo = quo + 1;
		return q_from_mag((a < 0) != (b < 0), quo);
	endfunction

	// one follower update: advances the held state, returns the result
	function automatic out_item_t follow_step(in_item_t it);
		longint tgt, orig, dt, omega, x, x2, x3, den, decay, max_chg;
		longint chg, chg_abs, temp, nvel, res, pos;
		out_item_t r;
		tgt = longint'($signed(it.target));
		dt = longint'({47'b0, it.delta_time});
		omega = q_div(2 * ONE_Q, cfg_smooth);
		x = q_mul(omega, dt);
		x2 = q_mul(x, x);
		x3 = q_mul(x2, x);
		den = q_sat(ONE_Q + x);
		den = q_sat(den + q_mul(K048, x2));
		den = q_sat(den + q_mul(K0235, x3));
		decay = q_div(ONE_Q, den);
		max_chg = q_mul(cfg_speed, dt);
		orig = tgt;
		chg = q_sat(held_pos - tgt);
		chg_abs = chg < 0 ? -chg : chg;
		// speed limit pulls the target in as well
		if (chg_abs > max_chg) begin
			chg = chg > 0 ? max_chg : -max_chg;
			tgt = q_sat(held_pos - chg);
		end
		temp = q_mul(q_sat(held_vel + q_mul(omega, chg)), dt);
		nvel = q_mul(q_sat(held_vel - q_mul(omega, temp)), decay);
		res = q_sat(tgt + q_mul(q_sat(chg + temp), decay));
		// overshoot guard against the original target
		if ((held_pos > orig) == (res > orig)) begin
			pos = res;
			r.snapped = 1'b0;
		end else begin
			nvel = q_div(q_sat(res - orig), dt);
			pos = orig;
			r.snapped = 1'b1;
		end
		held_pos = pos;
		held_vel = nvel;
		r.position = pos[VAL_W-1:0];
		r.velocity = nvel[VAL_W-1:0];
		return r;
	endfunction

	// random target: mostly held goals so the follower settles and overshoots
	function automatic in_item_t next_target();
		in_item_t it;
		int pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			// keep the current goal
		end else if (pick < 78) begin
			goal = int'($urandom_range(0, 2097152)) - 1048576;
		end else if (pick < 92) begin
			goal = $urandom;
		end else begin
			case ($urandom_range(4))
				0: goal = 32'sh7FFF_FFFF;
				1: goal = 32'sh8000_0000;
				2: goal = 0;
				3: goal = 1;
				default: goal = -1;
			endcase
		end
		it.target = goal;
		pick = $urandom_range(99);
		if (pick < 40) it.delta_time = DT_W'($urandom_range(500, 3000));
		else if (pick < 72) it.delta_time = DT_W'($urandom_range(1, 65536));
		else if (pick < 84) it.delta_time = DT_W'($urandom_range(1, 16));
		else it.delta_time = 65536;
		return it;
	endfunction

	task automatic push_item(logic signed [VAL_W-1:0] tgt, logic [DT_W-1:0] dt);
		in_item_t it;
		it.target = tgt;
		it.delta_time = dt;
		target_queue.push_back(it);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SMOOTH_TIME) cfg_smooth = longint'({33'b0, val});
		else cfg_speed = longint'({33'b0, val});
	endtask

	// block is idle once nothing is queued, offered or outstanding
	task automatic wait_drained();
		while (target_queue.size() != 0 || item_valid || predicted_moves.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// no new random gaps start on either side inside this window
	wire quiet = (cycle_no >= 30000) && (cycle_no < 70000);

	// driver: offers queued transactions, random gaps on both sides
	always @(negedge clk) begin
		if (arst_n) begin
			if (send_gap > 0) send_gap--;
			else if (!quiet && $urandom_range(99) == 0) send_gap = $urandom_range(11, 1);
			if (recv_gap > 0) recv_gap--;
			else if (!quiet && $urandom_range(99) == 0) recv_gap = $urandom_range(11, 1);
			result_ready <= (recv_gap == 0);
			if (!item_valid || item_taken) begin
				if (send_gap == 0 && target_queue.size() != 0) begin
					item <= target_queue.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: predicts on each accepted item, checks each accepted result
	always @(posedge clk) begin : watch
		out_item_t want;
		cycle_no++;
		item_taken = arst_n && item_valid && item_ready;
		if (item_taken)
			predicted_moves.push_back(follow_step(item));
		if (arst_n && result_valid && result_ready) begin
			if (predicted_moves.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result at %0t: pos %0d vel %0d snap %0b",
						$realtime, $signed(result.position),
						$signed(result.velocity), result.snapped);
				mismatch_count++;
			end else begin
				want = predicted_moves.pop_front();
				if (result.position !== want.position || result.velocity !== want.velocity ||
						result.snapped !== want.snapped) begin
					if (mismatch_count < 10)
						$display({"mismatch at %0t: expected pos %0d vel %0d snap %0b,",
							" got pos %0d vel %0d snap %0b"},
							$realtime, $signed(want.position), $signed(want.velocity),
							want.snapped, $signed(result.position),
							$signed(result.velocity), result.snapped);
					mismatch_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: extremes, zero time step, settling and overshoot
		push_item(0, 65536);
		push_item(32'sh7FFF_FFFF, 65536);
		push_item(32'sh8000_0000, 65536);
		push_item(32'sh7FFF_FFFF, 1);
		push_item(32'sh0001_0000, 0);
		push_item(-32'sh0001_0000, 0);
		push_item(0, 1);
		repeat (4) push_item(32'sh000A_0000, 4369);
		repeat (3) push_item(-32'sh000A_0000, 65536);
		push_item(-1, 0);
		for (int n = 0; n < RANDOM_PER_PHASE; n++) target_queue.push_back(next_target());

		for (int p = 1; p < PHASES; p++) begin
			wait_drained();
			case (p)
				1: begin
					write_reg(REG_SMOOTH_TIME, 31'h7FFF_FFFF);
					write_reg(REG_MAX_SPEED, 31'h7FFF_FFFF);
				end
				2: begin
					write_reg(REG_SMOOTH_TIME, 31'd1);
					write_reg(REG_MAX_SPEED, 31'd0);
				end
				3: begin
					// zero smooth_time gives the largest omega
					write_reg(REG_SMOOTH_TIME, 31'd0);
					write_reg(REG_MAX_SPEED, 31'd65536);
					push_item(32'sh0064_0000, 65536);
					push_item(-32'sh0064_0000, 65536);
				end
				4: begin
					write_reg(REG_SMOOTH_TIME, 31'd32768);
					write_reg(REG_MAX_SPEED, 31'd655360);
					push_item(32'sh0064_0000, 65536);
					push_item(32'sh0064_0000, 1092);
				end
				default: begin
					write_reg(REG_SMOOTH_TIME, CFG_W'($urandom_range(1024, 524288)));
					if ($urandom_range(1))
						write_reg(REG_MAX_SPEED, CFG_W'($urandom_range(0, 32'h7FFF_FFFF)));
					else
						write_reg(REG_MAX_SPEED, CFG_W'($urandom_range(0, 2097152)));
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) target_queue.push_back(next_target());
		end

		wait_drained();
		repeat (300) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#8_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
